// ===== hdl/sma_pkg.sv =====
// Package with opcodes, status codes, controller states and shared structs of the stack ALU.
package sma_pkg;

   localparam int STACK_DEPTH_DEFAULT = 64;
   localparam int DATA_WIDTH = 32;
   localparam int ACTION_WIDTH = 4;
   localparam int DEPTH_FIELD_WIDTH = 7;
   localparam int STATUS_WIDTH = 2;

   typedef enum logic [ACTION_WIDTH-1:0] {
      OP_CONST = 4'd0,
      OP_ADD   = 4'd1,
      OP_SUB   = 4'd2,
      OP_MUL   = 4'd3,
      OP_DIV   = 4'd4,
      OP_MAX   = 4'd5,
      OP_MIN   = 4'd6,
      OP_NEG   = 4'd7,
      OP_DUP   = 4'd8,
      OP_SWAP  = 4'd9
   } opcode_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_OK    = 2'd0,
      ST_UNDER = 2'd1,
      ST_OVER  = 2'd2,
      ST_DIVZ  = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_READ_A,
      S_READ_B,
      S_EXEC,
      S_DIV,
      S_MUL,
      S_WRITE,
      S_WRITE2,
      S_TOP_READ,
      S_TOP_LOAD,
      S_OUT
   } state_type;

   typedef struct packed {
      logic       load_item;
      logic       read_top;
      logic       read_second;
      logic       latch_a;
      logic       div_start;
      logic       mul_start;
      logic [2:0] write_sel;
      logic       write_top;
      logic       write_second;
      logic       write_push;
      logic       count_inc;
      logic       count_dec;
      logic       top_read;
      logic       top_load;
      logic       set_status;
      status_type status;
   } cmd_type;

   typedef struct packed {
      opcode_type action;
      logic       empty;
      logic       one_or_less;
      logic       full;
      logic       b_zero;
      logic       div_done;
      logic       mul_done;
   } stat_type;

   localparam logic [2:0] WSEL_OPERAND = 3'd0;
   localparam logic [2:0] WSEL_A       = 3'd1;
   localparam logic [2:0] WSEL_B       = 3'd2;
   localparam logic [2:0] WSEL_ALU     = 3'd3;
   localparam logic [2:0] WSEL_DIV     = 3'd4;
   localparam logic [2:0] WSEL_MUL     = 3'd5;
   localparam logic [2:0] WSEL_NEG     = 3'd6;

endpackage

// ===== hdl/sma_ctrl.sv =====
// Controller state machine that sequences stack reads, arithmetic and writes per instruction.
module sma_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  sma_pkg::stat_type stat,
   output sma_pkg::cmd_type  cmd
);
   import sma_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      cmd.status   = ST_OK;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load_item = 1'b1;
               state_in      = S_READ_A;
            end
         end
         S_READ_A: begin
            cmd.read_top = 1'b1;
            state_in     = S_READ_B;
         end
         S_READ_B: begin
            cmd.latch_a     = 1'b1;
            cmd.read_second = 1'b1;
            state_in        = S_EXEC;
         end
         S_EXEC: begin
            cmd.set_status = 1'b1;
            state_in       = S_TOP_READ;
            case (stat.action)
               OP_CONST: begin
                  if (stat.full) begin
                     cmd.status = ST_OVER;
                  end else begin
                     cmd.write_push = 1'b1;
                     cmd.write_sel  = WSEL_OPERAND;
                     cmd.count_inc  = 1'b1;
                  end
               end
               OP_DUP: begin
                  if (stat.empty) begin
                     cmd.status = ST_UNDER;
                  end else if (stat.full) begin
                     cmd.status = ST_OVER;
                  end else begin
                     cmd.write_push = 1'b1;
                     cmd.write_sel  = WSEL_A;
                     cmd.count_inc  = 1'b1;
                  end
               end
               OP_NEG: begin
                  if (stat.empty) begin
                     cmd.status = ST_UNDER;
                  end else begin
                     cmd.write_top = 1'b1;
                     cmd.write_sel = WSEL_NEG;
                  end
               end
               OP_ADD, OP_SUB, OP_MAX, OP_MIN: begin
                  if (stat.one_or_less) begin
                     cmd.status = ST_UNDER;
                  end else begin
                     cmd.write_second = 1'b1;
                     cmd.write_sel    = WSEL_ALU;
                     cmd.count_dec    = 1'b1;
                  end
               end
               OP_MUL: begin
                  if (stat.one_or_less) begin
                     cmd.status = ST_UNDER;
                  end else begin
                     cmd.mul_start = 1'b1;
                     state_in      = S_MUL;
                  end
               end
               OP_DIV: begin
                  if (stat.one_or_less) begin
                     cmd.status = ST_UNDER;
                  end else if (stat.b_zero) begin
                     cmd.status = ST_DIVZ;
                  end else begin
                     cmd.div_start = 1'b1;
                     state_in      = S_DIV;
                  end
               end
               OP_SWAP: begin
                  if (stat.one_or_less) begin
                     cmd.status = ST_UNDER;
                  end else begin
                     cmd.write_top = 1'b1;
                     cmd.write_sel = WSEL_B;
                     state_in      = S_WRITE2;
                  end
               end
               default: begin
               end
            endcase
         end
         S_MUL: begin
            if (stat.mul_done) begin
               cmd.write_second = 1'b1;
               cmd.write_sel    = WSEL_MUL;
               cmd.count_dec    = 1'b1;
               state_in         = S_TOP_READ;
            end
         end
         S_DIV: begin
            if (stat.div_done) begin
               cmd.write_second = 1'b1;
               cmd.write_sel    = WSEL_DIV;
               cmd.count_dec    = 1'b1;
               state_in         = S_TOP_READ;
            end
         end
         S_WRITE2: begin
            cmd.write_second = 1'b1;
            cmd.write_sel    = WSEL_A;
            state_in         = S_TOP_READ;
         end
         S_WRITE: begin
            state_in = S_TOP_READ;
         end
         S_TOP_READ: begin
            cmd.top_read = 1'b1;
            state_in     = S_TOP_LOAD;
         end
         S_TOP_LOAD: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.top_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_OUT: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== hdl/sma_div.sv =====
// Iterative signed divider producing one quotient bit per cycle, truncating toward zero.
module sma_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [sma_pkg::DATA_WIDTH-1:0]  dividend,
   input  logic [sma_pkg::DATA_WIDTH-1:0]  divisor,
   output logic                            done,
   output logic [sma_pkg::DATA_WIDTH-1:0]  quotient
);
   import sma_pkg::*;

   localparam int CW = $clog2(DATA_WIDTH + 1);

   logic [DATA_WIDTH-1:0] quo_ff, quo_in;
   logic [DATA_WIDTH-1:0] rem_ff, rem_in;
   logic [DATA_WIDTH-1:0] den_ff, den_in;
   logic                  neg_ff, neg_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DATA_WIDTH:0]   trial;
   logic [DATA_WIDTH:0]   shifted;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
   end

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff, quo_ff[DATA_WIDTH-1]};
      trial   = shifted - {1'b0, den_ff};
      if (start) begin
         quo_in  = dividend[DATA_WIDTH-1] ? (~dividend + 1'b1) : dividend;
         den_in  = divisor[DATA_WIDTH-1] ? (~divisor + 1'b1) : divisor;
         neg_in  = dividend[DATA_WIDTH-1] ^ divisor[DATA_WIDTH-1];
         rem_in  = '0;
         cnt_in  = CW'(DATA_WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[DATA_WIDTH]) begin
            rem_in = trial[DATA_WIDTH-1:0];
            quo_in = {quo_ff[DATA_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = shifted[DATA_WIDTH-1:0];
            quo_in = {quo_ff[DATA_WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? (~quo_ff + 1'b1) : quo_ff;

endmodule

// ===== hdl/sma_datapath.sv =====
// Datapath with the stack memory, entry counter, operand registers, ALU, multiplier and result register.
module sma_datapath #(
   parameter int STACK_DEPTH = sma_pkg::STACK_DEPTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic [sma_pkg::ACTION_WIDTH-1:0]       action,
   input  logic [sma_pkg::DATA_WIDTH-1:0]         operand,
   input  sma_pkg::cmd_type                       cmd,
   output sma_pkg::stat_type                      stat,
   output logic [sma_pkg::DATA_WIDTH-1:0]         top_value,
   output logic [sma_pkg::DEPTH_FIELD_WIDTH-1:0]  depth,
   output logic [sma_pkg::STATUS_WIDTH-1:0]       status
);
   import sma_pkg::*;

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int NW = $clog2(STACK_DEPTH + 1);

   logic [DATA_WIDTH-1:0]   mem [STACK_DEPTH];
   logic [DATA_WIDTH-1:0]   rd_data_ff;
   logic [ACTION_WIDTH-1:0] action_ff;
   logic [DATA_WIDTH-1:0]   operand_ff;
   logic [NW-1:0]           count_ff, count_in;
   logic [DATA_WIDTH-1:0]   a_ff;
   logic [2*DATA_WIDTH-1:0] prod_ff;
   logic                    mul_done_ff;
   logic [DATA_WIDTH-1:0]   top_ff;
   logic [NW-1:0]           depth_ff;
   logic [STATUS_WIDTH-1:0] status_ff;
   logic [STATUS_WIDTH-1:0] status_hold_ff;
   logic                    rd_en;
   logic [AW-1:0]           rd_addr;
   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   logic [DATA_WIDTH-1:0]   wr_data;
   logic [DATA_WIDTH-1:0]   alu_res;
   logic [DATA_WIDTH-1:0]   quotient;
   logic                    div_done;
   logic                    b_zero;
   logic [NW-1:0]           top_idx;
   logic [NW-1:0]           second_idx;

   assign top_idx    = count_ff - 1'b1;
   assign second_idx = count_ff - NW'(2);

   sma_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (a_ff),
      .divisor  (rd_data_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= '0;
         mul_done_ff    <= 1'b0;
         status_hold_ff <= ST_OK;
      end else begin
         count_ff    <= count_in;
         mul_done_ff <= cmd.mul_start;
         if (cmd.set_status) begin
            status_hold_ff <= cmd.status;
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.count_inc) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.count_dec) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_comb begin
      rd_en   = cmd.read_top || cmd.read_second || cmd.top_read;
      rd_addr = cmd.read_second ? second_idx[AW-1:0] : top_idx[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         action_ff  <= action;
         operand_ff <= operand;
      end
      if (cmd.latch_a) begin
         a_ff <= rd_data_ff;
      end
      if (cmd.mul_start) begin
         prod_ff <= a_ff * rd_data_ff;
      end
      if (cmd.top_load) begin
         top_ff    <= (count_ff == '0) ? '0 : rd_data_ff;
         depth_ff  <= count_ff;
         status_ff <= status_hold_ff;
      end
   end

   // The second entry sits in rd_data_ff during the execute cycle.
   assign b_zero = (rd_data_ff == '0);

   always_comb begin
      case (opcode_type'(action_ff))
         OP_ADD:  alu_res = a_ff + rd_data_ff;
         OP_SUB:  alu_res = a_ff - rd_data_ff;
         OP_MAX:  alu_res = ($signed(rd_data_ff) < $signed(a_ff)) ? a_ff : rd_data_ff;
         OP_MIN:  alu_res = ($signed(a_ff) < $signed(rd_data_ff)) ? a_ff : rd_data_ff;
         default: alu_res = a_ff;
      endcase
   end

   always_comb begin
      wr_en   = cmd.write_push || cmd.write_top || cmd.write_second;
      wr_addr = top_idx[AW-1:0];
      if (cmd.write_push) begin
         wr_addr = count_ff[AW-1:0];
      end else if (cmd.write_second) begin
         wr_addr = second_idx[AW-1:0];
      end
      case (cmd.write_sel)
         WSEL_OPERAND: wr_data = operand_ff;
         WSEL_A:       wr_data = a_ff;
         WSEL_B:       wr_data = rd_data_ff;
         WSEL_ALU:     wr_data = alu_res;
         WSEL_DIV:     wr_data = quotient;
         WSEL_MUL:     wr_data = prod_ff[DATA_WIDTH-1:0];
         WSEL_NEG:     wr_data = ~a_ff + 1'b1;
         default:      wr_data = a_ff;
      endcase
   end

   always_comb begin
      stat             = '0;
      stat.action      = opcode_type'(action_ff);
      stat.empty       = (count_ff == '0);
      stat.one_or_less = (count_ff < NW'(2));
      stat.full        = (count_ff >= NW'(STACK_DEPTH));
      stat.b_zero      = b_zero;
      stat.div_done    = div_done;
      stat.mul_done    = mul_done_ff;
   end

   assign top_value = top_ff;
   assign depth     = DEPTH_FIELD_WIDTH'(depth_ff);
   assign status    = status_ff;

endmodule

// ===== hdl/stack_machine_alu.sv =====
// Top level of the fixed-depth stack machine ALU: controller plus datapath.
//
// One instruction word enters on the req_ channel (action and operand) and
// one result word leaves on the rsp_ channel (top value, depth, status).
// The block works on one instruction at a time; req_tready is high only
// while the controller is idle. From acceptance to rsp_tvalid, simple
// opcodes pass through two stack reads, one execute and write, one read
// of the new top and the load of the result register. MUL waits in
// addition for the registered product. DIV runs a 32-step shift-subtract
// loop and a registered done flag before its write. The stack lives in a
// single-port-write, single-port-read memory of STACK_DEPTH words.
// A result word is held in its output register until rsp_tready is seen;
// the controller waits for the register to free before loading the next
// result, so a stalled receiver stalls the block without loss.
// Reset clears the entry count, the controller and rsp_tvalid; the stack
// memory needs no clearing since data read from empty slots is never used.
module stack_machine_alu #(
   parameter int STACK_DEPTH = sma_pkg::STACK_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // action [3:0], operand [35:4], zero pad [39:36]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata   // top_value [31:0], depth [38:32], status [40:39], pad
);
   import sma_pkg::*;

   cmd_type                        cmd;
   stat_type                       stat;
   logic [DATA_WIDTH-1:0]          top_value;
   logic [DEPTH_FIELD_WIDTH-1:0]   depth;
   logic [STATUS_WIDTH-1:0]        status;

   sma_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   sma_datapath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .action    (req_tdata[3:0]),
      .operand   (req_tdata[35:4]),
      .cmd       (cmd),
      .stat      (stat),
      .top_value (top_value),
      .depth     (depth),
      .status    (status)
   );

   assign rsp_tdata = {7'd0, status, depth, top_value};

endmodule
